FILE: src/cop_pkg.sv
// shared constants and types for the conic outline pixel test
`default_nettype none

package cop_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 4;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TARGET_W   = 16;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned FRONT_LAT = 2;
  localparam int unsigned JUDGE_LAT = 2;

  localparam int unsigned RST_FOCUS_A_X = 320;
  localparam int unsigned RST_FOCUS_A_Y = 240;
  localparam int unsigned RST_FOCUS_B_X = 400;
  localparam int unsigned RST_FOCUS_B_Y = 280;
  localparam logic [TARGET_W-1:0] RST_TARGET    = 16'd3200;
  localparam logic [TARGET_W-1:0] RST_TOLERANCE = 16'd16;
  localparam logic [COLOR_W-1:0]  RST_COLOR     = 24'h873228;

  typedef enum logic [MODE_W-1:0] {
    MODE_CIRCLE    = 2'd0,
    MODE_ELLIPSE   = 2'd1,
    MODE_HYPERBOLA = 2'd2,
    MODE_PARABOLA  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE = 4'd0,
    REG_FOCUS_A_X  = 4'd1,
    REG_FOCUS_A_Y  = 4'd2,
    REG_FOCUS_B_X  = 4'd3,
    REG_FOCUS_B_Y  = 4'd4,
    REG_TARGET     = 4'd5,
    REG_TOLERANCE  = 4'd6,
    REG_COLOR      = 4'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: src/cop_front.sv
// front end: focus offsets, then squared distances as root radicands
`default_nettype none

module cop_front import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned ROOT_W     = COORD_BITS + FRAC_BITS + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [COORD_BITS-1:0]   px_i,
  input  wire logic [COORD_BITS-1:0]   py_i,
  input  wire logic [COORD_BITS-1:0]   fax_i,
  input  wire logic [COORD_BITS-1:0]   fay_i,
  input  wire logic [COORD_BITS-1:0]   fbx_i,
  input  wire logic [COORD_BITS-1:0]   fby_i,
  output logic      [2*ROOT_W-1:0]     rad_a_o,
  output logic      [2*ROOT_W-1:0]     rad_b_o
);

  localparam int unsigned SQ_W  = 2 * COORD_BITS + 1;
  localparam int unsigned RAD_W = 2 * ROOT_W;

  logic [COORD_BITS-1:0] dxa_d, dya_d, dxb_d, dyb_d;
  logic [COORD_BITS-1:0] dxa_q, dya_q, dxb_q, dyb_q;
  logic [2*COORD_BITS-1:0] pxa, pya, pxb, pyb;
  logic [SQ_W-1:0] sq_a_d, sq_b_d, sq_a_q, sq_b_q;

  assign dxa_d = (px_i >= fax_i) ? px_i - fax_i : fax_i - px_i;
  assign dya_d = (py_i >= fay_i) ? py_i - fay_i : fay_i - py_i;
  assign dxb_d = (px_i >= fbx_i) ? px_i - fbx_i : fbx_i - px_i;
  assign dyb_d = (py_i >= fby_i) ? py_i - fby_i : fby_i - py_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxa_q <= dxa_d;
      dya_q <= dya_d;
      dxb_q <= dxb_d;
      dyb_q <= dyb_d;
    end
  end

  assign pxa = dxa_q * dxa_q;
  assign pya = dya_q * dya_q;
  assign pxb = dxb_q * dxb_q;
  assign pyb = dyb_q * dyb_q;
  assign sq_a_d = SQ_W'(pxa) + SQ_W'(pya);
  assign sq_b_d = SQ_W'(pxb) + SQ_W'(pyb);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_a_q <= sq_a_d;
      sq_b_q <= sq_b_d;
    end
  end

  // scale to fixed point before the root
  assign rad_a_o = RAD_W'(sq_a_q) << (2 * FRAC_BITS);
  assign rad_b_o = RAD_W'(sq_b_q) << (2 * FRAC_BITS);

endmodule

`default_nettype wire

FILE: src/cop_isqrt.sv
// pipelined floor square root, one root bit per stage
`default_nettype none

module cop_isqrt import cop_pkg::*; #(
  parameter int unsigned ROOT_W = COORD_BITS_DEF + FRAC_BITS_DEF + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [2*ROOT_W-1:0]   radicand_i,
  output logic      [ROOT_W-1:0]     root_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [ROOT_W-1];
  logic [REM_W-1:0]  rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    if (s == 0) begin : g_first
      assign rad_in  = radicand_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // remainder stays below 2^ROOT_W, so its top two bits are always zero
    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1-2*s -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= {root_in[ROOT_W-2:0], fits};
      end
    end

    if (s < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s] <= rad_in;
          rem_q[s] <= fits ? rem_sh - trial : rem_sh;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: src/cop_judge.sv
// curve term selection by mode, then deviation against tolerance
`default_nettype none

module cop_judge import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned ROOT_W     = COORD_BITS + FRAC_BITS + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [ROOT_W-1:0]       d1_i,
  input  wire logic [ROOT_W-1:0]       d2_i,
  input  wire logic [COORD_BITS-1:0]   x_i,
  input  wire logic [COORD_BITS-1:0]   y_i,
  input  wire mode_e                   mode_i,
  input  wire logic [COORD_BITS-1:0]   fbx_i,
  input  wire logic [TARGET_W-1:0]     target_i,
  input  wire logic [TARGET_W-1:0]     tol_i,
  output logic      [COORD_BITS-1:0]   x_o,
  output logic      [COORD_BITS-1:0]   y_o,
  output logic                         hit_o
);

  localparam int unsigned DEV_W = (ROOT_W + 1 > TARGET_W) ? ROOT_W + 1 : TARGET_W;

  logic [DEV_W-1:0]      focal_sum;
  logic [ROOT_W-1:0]     focal_gap;
  logic [COORD_BITS-1:0] dir_dx;
  logic [DEV_W-1:0]      dir_dist;
  logic [DEV_W-1:0]      term_d, term_q;
  logic [DEV_W-1:0]      goal_d, goal_q;
  logic [COORD_BITS-1:0] x1_q, y1_q;
  logic [DEV_W-1:0]      dev;
  logic [COORD_BITS-1:0] x2_q, y2_q;
  logic                  hit_q;

  assign focal_sum = DEV_W'(d1_i) + DEV_W'(d2_i);
  assign focal_gap = (d1_i >= d2_i) ? d1_i - d2_i : d2_i - d1_i;
  assign dir_dx    = (x_i >= fbx_i) ? x_i - fbx_i : fbx_i - x_i;
  assign dir_dist  = DEV_W'(dir_dx) << FRAC_BITS;

  always_comb begin
    case (mode_i)
      MODE_CIRCLE: begin
        term_d = DEV_W'(d1_i);
        goal_d = DEV_W'(target_i);
      end
      MODE_ELLIPSE: begin
        term_d = focal_sum;
        goal_d = DEV_W'(target_i);
      end
      MODE_HYPERBOLA: begin
        term_d = DEV_W'(focal_gap);
        goal_d = DEV_W'(target_i);
      end
      MODE_PARABOLA: begin
        // directrix is the vertical line at the second focus x
        term_d = DEV_W'(d1_i);
        goal_d = dir_dist;
      end
      default: begin
        term_d = DEV_W'(d1_i);
        goal_d = DEV_W'(target_i);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= term_d;
      goal_q <= goal_d;
      x1_q   <= x_i;
      y1_q   <= y_i;
    end
  end

  assign dev = (term_q >= goal_q) ? term_q - goal_q : goal_q - term_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= (dev < DEV_W'(tol_i));
      x2_q  <= x1_q;
      y2_q  <= y1_q;
    end
  end

  assign x_o   = x2_q;
  assign y_o   = y2_q;
  assign hit_o = hit_q;

endmodule

`default_nettype wire

FILE: src/conic_outline_pixel_test.sv
// Conic outline pixel test: takes one pixel per clock, unless a result waits at the output,
// and reports whether it lies on the configured circle, ellipse, hyperbola or parabola,
// judged by focal distances in fixed point with FRAC_BITS fraction bits. Each request
// comes back with the coordinate, the hit flag and the draw color; results keep request
// order. The pipeline is the square root pipeline, which resolves one root bit per stage
// for both foci side by side, plus two front stages and two compare stages. The whole
// pipeline holds while a result waits at the output. Configuration writes are taken at
// any time, but belong only in cycles with no request in flight; indexes above the
// register list are ignored.
`default_nettype none

module conic_outline_pixel_test import cop_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [COORD_BITS-1:0]   pixel_x_i,
  input  wire logic [COORD_BITS-1:0]   pixel_y_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [COORD_BITS-1:0]   out_x_o,
  output logic      [COORD_BITS-1:0]   out_y_o,
  output logic                         on_curve_o,
  output logic      [COLOR_W-1:0]      pixel_color_o
);

  localparam int unsigned ROOT_W   = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned SIDE_LAT = FRONT_LAT + ROOT_W;
  localparam int unsigned LAT      = SIDE_LAT + JUDGE_LAT;

  mode_e                 mode_q;
  logic [COORD_BITS-1:0] fax_q, fay_q, fbx_q, fby_q;
  logic [TARGET_W-1:0]   target_q, tol_q;
  logic [COLOR_W-1:0]    color_q;

  logic                  en;
  logic                  vld_q [LAT];
  logic [COORD_BITS-1:0] px_q  [SIDE_LAT];
  logic [COORD_BITS-1:0] py_q  [SIDE_LAT];

  logic [2*ROOT_W-1:0]   rad_a, rad_b;
  logic [ROOT_W-1:0]     d1, d2;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CIRCLE;
      fax_q    <= COORD_BITS'(RST_FOCUS_A_X);
      fay_q    <= COORD_BITS'(RST_FOCUS_A_Y);
      fbx_q    <= COORD_BITS'(RST_FOCUS_B_X);
      fby_q    <= COORD_BITS'(RST_FOCUS_B_Y);
      target_q <= RST_TARGET;
      tol_q    <= RST_TOLERANCE;
      color_q  <= RST_COLOR;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CURVE_MODE: mode_q   <= mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_FOCUS_A_X:  fax_q    <= cfg_data_i[COORD_BITS-1:0];
        REG_FOCUS_A_Y:  fay_q    <= cfg_data_i[COORD_BITS-1:0];
        REG_FOCUS_B_X:  fbx_q    <= cfg_data_i[COORD_BITS-1:0];
        REG_FOCUS_B_Y:  fby_q    <= cfg_data_i[COORD_BITS-1:0];
        REG_TARGET:     target_q <= cfg_data_i[TARGET_W-1:0];
        REG_TOLERANCE:  tol_q    <= cfg_data_i[TARGET_W-1:0];
        REG_COLOR:      color_q  <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds an untaken result
  assign en         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // coordinates ride alongside the distance pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= pixel_x_i;
      py_q[0] <= pixel_y_i;
      for (int i = 1; i < SIDE_LAT; i++) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
      end
    end
  end

  cop_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ROOT_W     (ROOT_W)
  ) u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .px_i    (pixel_x_i),
    .py_i    (pixel_y_i),
    .fax_i   (fax_q),
    .fay_i   (fay_q),
    .fbx_i   (fbx_q),
    .fby_i   (fby_q),
    .rad_a_o (rad_a),
    .rad_b_o (rad_b)
  );

  cop_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_root_a (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (rad_a),
    .root_o     (d1)
  );

  cop_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_root_b (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (rad_b),
    .root_o     (d2)
  );

  cop_judge #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ROOT_W     (ROOT_W)
  ) u_judge (
    .clk_i    (clk_i),
    .en_i     (en),
    .d1_i     (d1),
    .d2_i     (d2),
    .x_i      (px_q[SIDE_LAT-1]),
    .y_i      (py_q[SIDE_LAT-1]),
    .mode_i   (mode_q),
    .fbx_i    (fbx_q),
    .target_i (target_q),
    .tol_i    (tol_q),
    .x_o      (out_x_o),
    .y_o      (out_y_o),
    .hit_o    (on_curve_o)
  );

  assign out_valid_o   = vld_q[LAT-1];
  assign pixel_color_o = color_q;

endmodule

`default_nettype wire
